// ===== rtl/kmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants of the stream matcher: action codes, symbol
// width and the control word broadcast to every cell of the row.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // symbol width, fixed by the beat format
  localparam int unsigned SymW = 32;

  // action codes of an input beat
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } kmp_action_e;

  // per-beat control seen by all cells, already qualified by the fire strobe
  typedef struct packed {
    logic clear;
    logic append;
    logic text;
  } kmp_cell_ctrl_t;

endpackage

// ===== rtl/kmp_stream_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Streaming pattern matcher over 32-bit symbols built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (action_i, symbol_i) with in_valid_i / in_stall_o carries
//   one beat: clear, append a pattern symbol, or feed a text symbol.
//   Output channel (match_o, found_o, pattern_full_o) with out_valid_o /
//   out_stall_i returns exactly one beat per input beat, in order.
//   A beat is captured in an input register and resolved by all cells once
//   the output register is empty or not stalled; its result is registered
//   in the output register at the edge where the cells resolve it.
//   The input register holds one beat and frees at the edge where the
//   cells resolve it; no new beat is accepted while it holds one.
//   The cell row compares the symbol against every pattern position at once,
//   so the cost does not depend on the pattern length or on overlaps.
//   When the receiver stalls, the result holds in the output register and
//   the pending beat waits in the input register; in_stall_o rises.
//   Reset empties the pattern, the match progress and the found flag.
//   Up to MAX_PATTERN pattern symbols are held; more are dropped and flagged.
// ----------------------------------------------------------------------------
module kmp_stream_matcher
  import kmp_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] symbol_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               match_o,
  output logic               found_o,
  output logic               pattern_full_o
);

  // input register
  logic              in_vld_q;
  kmp_action_e       act_q;
  logic [SymW-1:0]   sym_q;
  logic              fire;
  logic              in_take;

  // output register and sticky flag
  logic              out_vld_q;
  logic              match_q, match_d;
  logic              found_q, found_d;
  logic              full_q, full_d;

  // cell row
  kmp_cell_ctrl_t         ctrl;
  logic [MAX_PATTERN-1:0] occ_vec;
  logic [MAX_PATTERN-1:0] hit_vec;
  logic [MAX_PATTERN-1:0] match_vec;

  // handshake
  assign in_stall_o = in_vld_q;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign fire       = in_vld_q & (~out_vld_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        found_q   <= found_d;
      end else if (~out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // beat payload capture
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q <= kmp_action_e'(action_i);
      sym_q <= $unsigned(symbol_i);
    end
  end

  // control word for the cells
  always_comb begin
    ctrl = '0;
    if (fire) begin
      case (act_q)
        ACT_CLEAR:   ctrl.clear  = 1'b1;
        ACT_PATTERN: ctrl.append = 1'b1;
        ACT_TEXT:    ctrl.text   = 1'b1;
        default:     ctrl        = '0;
      endcase
    end
  end

  // row of cells, partial match bits shift toward higher positions
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic prev_occ, prev_hit, next_occ;
    if (j == 0) begin : g_first
      assign prev_occ = 1'b1;
      assign prev_hit = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ_vec[j-1];
      assign prev_hit = hit_vec[j-1];
    end
    if (j == MAX_PATTERN - 1) begin : g_last
      assign next_occ = 1'b0;
    end else begin : g_inner
      assign next_occ = occ_vec[j+1];
    end

    kmp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sym_i      (sym_q),
      .prev_occ_i (prev_occ),
      .prev_hit_i (prev_hit),
      .next_occ_i (next_occ),
      .occ_o      (occ_vec[j]),
      .hit_o      (hit_vec[j]),
      .match_o    (match_vec[j])
    );
  end

  // result of the beat being resolved
  always_comb begin
    match_d = 1'b0;
    full_d  = 1'b0;
    found_d = found_q;
    case (act_q)
      ACT_CLEAR: begin
        found_d = 1'b0;
      end
      ACT_PATTERN: begin
        full_d = occ_vec[MAX_PATTERN-1];
      end
      ACT_TEXT: begin
        // an empty pattern matches at every text symbol
        match_d = ~occ_vec[0] | (|match_vec);
        found_d = found_q | match_d;
      end
      default: begin
        match_d = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      match_q <= match_d;
      full_q  <= full_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign match_o        = match_q;
  assign found_o        = found_q;
  assign pattern_full_o = full_q;

endmodule

// ===== rtl/kmp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_cell
// One pattern position: holds its symbol, an occupied bit and the partial
// match bit that says the pattern prefix ending here is a suffix of the text.
// The match bit moves one cell up the row on every text beat.
// ----------------------------------------------------------------------------
module kmp_cell
  import kmp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kmp_cell_ctrl_t  ctrl_i,
  input  logic [SymW-1:0] sym_i,
  input  logic            prev_occ_i,
  input  logic            prev_hit_i,
  input  logic            next_occ_i,
  output logic            occ_o,
  output logic            hit_o,
  output logic            match_o
);

  logic [SymW-1:0] sym_q;
  logic            occ_q, occ_d;
  logic            hit_q, hit_d;
  logic            step;

  // prefix extends through this position on the current symbol
  assign step = prev_hit_i & occ_q & (sym_q == sym_i);

  // full occurrence when this is the last occupied cell
  assign match_o = ctrl_i.text & step & ~next_occ_i;

  // next occupied and partial match bits
  always_comb begin
    occ_d = occ_q;
    hit_d = hit_q;
    if (ctrl_i.clear) begin
      occ_d = 1'b0;
      hit_d = 1'b0;
    end else if (ctrl_i.append) begin
      if (prev_occ_i & ~occ_q) begin
        occ_d = 1'b1;
      end
    end else if (ctrl_i.text) begin
      // the last cell falls back: a full match leaves no partial bit here
      hit_d = step & next_occ_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      hit_q <= hit_d;
    end
  end

  // symbol store, written once when the cell is taken
  always_ff @(posedge clk_i) begin
    if (ctrl_i.append & prev_occ_i & ~occ_q) begin
      sym_q <= sym_i;
    end
  end

  assign occ_o = occ_q;
  assign hit_o = hit_q;

endmodule
